FILE: rtl/khr_pkg.sv
package khr_pkg;

    localparam logic [31:0] HASH_BASIS = 32'h8422_2325;
    localparam logic [31:0] HASH_MULT  = 32'h0000_01b3;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam int HASH_W  = 32;
    localparam int NODE_W  = 4;
    localparam int ENTRY_W = HASH_W + NODE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD_LAST,
        S_CHK,
        S_MID,
        S_CMP,
        S_NODE,
        S_CAP
    } state_t;

    typedef enum logic [2:0] {
        ADDR_LOAD,
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_MID,
        ADDR_PICK
    } addr_sel_t;

    typedef struct packed {
        logic      acc_step;
        logic      take_end;
        logic      ram_we;
        addr_sel_t addr_sel;
        logic      cap_first;
        logic      chk;
        logic      mid_lat;
        logic      cmp;
        logic      pick_hi;
        logic      load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic span_gt1;
        logic wrap;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/key_hash_ring_dispatch_top.sv
// Consistent-hash ring dispatcher.
// Input stream (s_*): each word is a request, its kind in s_tuser.
//   Load: write one ring point (hash, node) into the slot given; slots at
//   or beyond MAX_POINTS are dropped. The table must be sorted ascending.
//   Key byte: fold one byte into the 32-bit hash accumulator: xor, then multiply.
//   End of key: emit the hash and the owning node, restart the accumulator.
// Output stream (m_*): one word per end of key, shard index and key hash.
// Configuration: cfg_we writes point_count (number of valid points); the user
// must do so only while the block is idle, which the block does not enforce.
// Zero acts as one, values above MAX_POINTS saturate. Throughput: loads and
// key bytes go at one word per cycle while no search is running. An end-of-key
// word holds the input until its search is done, soonest when the key wraps
// to slot 0: each search step reads the single-port ring memory, then compares.
// When the receiver stalls, the result is held in the output register and
// the block keeps taking loads and bytes; a further end of key waits in the
// final step until the held word is taken.
// Reset clears the accumulator to its basis, point_count to one and drops
// any pending result; the ring table keeps no reset value and must be loaded.
module key_hash_ring_dispatch_top #(
    parameter int MAX_POINTS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,     // point_count
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // point_index[11:0], point_hash[43:12],
                                       // point_node[47:44], key_byte[55:48]
    input  logic [1:0]  s_tuser,       // req_type[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // shard_index[3:0], key_hash[35:4], zero[39:36]
);

    import khr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic [3:0]  shard_index;
    logic [31:0] key_hash;

    // Sequence the search and the handshake.
    khr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Hold the accumulator, the ring memory, the search window and the result.
    khr_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .point_index (s_tdata[11:0]),
        .point_hash  (s_tdata[43:12]),
        .point_node  (s_tdata[47:44]),
        .key_byte    (s_tdata[55:48]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .shard_index (shard_index),
        .key_hash    (key_hash)
    );

    assign m_tdata = {4'd0, key_hash, shard_index};

endmodule

FILE: rtl/khr_ram.sv
module khr_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/khr_ctrl.sv
module khr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic [1:0]          req_type,
    output logic                s_tready,
    input  khr_pkg::dp_status_t st,
    output khr_pkg::ctrl_cmd_t  cmd
);

    import khr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   s_accept;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept && req_type == REQ_END)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:     state_next = S_RD_LAST;
            S_RD_LAST: state_next = S_CHK;
            S_CHK:     state_next = st.wrap ? S_NODE : S_MID;
            S_MID:     state_next = st.span_gt1 ? S_CMP : S_NODE;
            S_CMP:     state_next = S_MID;
            S_NODE:    state_next = S_CAP;
            S_CAP:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.addr_sel = ADDR_LOAD;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (req_type)
                        REQ_LOAD: cmd.ram_we   = 1'b1;
                        REQ_BYTE: cmd.acc_step = 1'b1;
                        REQ_END:  cmd.take_end = 1'b1;
                        default:  ;
                    endcase
                end
            end
            S_RD0:     cmd.addr_sel = ADDR_ZERO;
            S_RD_LAST:
            begin
                cmd.addr_sel  = ADDR_LAST;
                cmd.cap_first = 1'b1;
            end
            S_CHK:     cmd.chk = 1'b1;
            S_MID:
            begin
                cmd.addr_sel = ADDR_MID;
                cmd.mid_lat  = st.span_gt1;
                cmd.pick_hi  = !st.span_gt1;
            end
            S_CMP:     cmd.cmp = 1'b1;
            S_NODE:    cmd.addr_sel = ADDR_PICK;
            S_CAP:
            begin
                cmd.addr_sel = ADDR_PICK;
                cmd.load_out = st.out_free;
            end
            default:   ;
        endcase
    end

    a_end_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && req_type == REQ_END) |=> state_reg == S_RD0)
        else $error("end of key did not start the ring search");

    a_search_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MID && !st.span_gt1) |=> state_reg == S_NODE)
        else $error("narrowed search did not go on to the node read");

endmodule

FILE: rtl/khr_dp.sv
module khr_dp #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  khr_pkg::ctrl_cmd_t  cmd,
    output khr_pkg::dp_status_t st,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_wdata,
    input  logic [11:0]         point_index,
    input  logic [31:0]         point_hash,
    input  logic [3:0]          point_node,
    input  logic [7:0]          key_byte,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [3:0]          shard_index,
    output logic [31:0]         key_hash
);

    import khr_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = (NW > 13) ? NW : 13;

    logic [12:0]        count_reg;
    logic [31:0]        acc_reg;
    logic [31:0]        acc_next;
    logic [31:0]        key_reg;
    logic               first_ge_reg;
    logic [NW-1:0]      lo_reg;
    logic [NW-1:0]      hi_reg;
    logic [NW-1:0]      mid_reg;
    logic [NW-1:0]      pick_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [3:0]         out_shard_reg;
    logic [31:0]        out_hash_reg;

    logic [CW-1:0]      count_ext;
    logic [CW-1:0]      count_clip;
    logic [NW-1:0]      count_eff;
    logic [NW:0]        mid_sum;
    logic [NW-1:0]      mid_comb;
    logic               slot_ok;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [31:0]        rd_hash;
    logic [3:0]         rd_node;

    // Zero counts as one point; clip the count to the table depth.
    assign count_ext  = CW'(count_reg);
    assign count_clip = (count_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : count_ext;
    assign count_eff  = (count_reg == 13'd0) ? NW'(1) : NW'(count_clip);

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_comb = mid_sum[NW:1];

    assign slot_ok   = 32'(point_index) < 32'(MAX_POINTS);
    assign ram_we    = cmd.ram_we && slot_ok;
    assign ram_wdata = {point_node, point_hash};
    assign rd_hash   = ram_rdata[HASH_W-1:0];
    assign rd_node   = ram_rdata[ENTRY_W-1:HASH_W];

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_LOAD: ram_addr = AW'(point_index);
            ADDR_ZERO: ram_addr = '0;
            ADDR_LAST: ram_addr = AW'(count_eff - NW'(1));
            ADDR_MID:  ram_addr = AW'(mid_comb);
            ADDR_PICK: ram_addr = AW'(pick_reg);
            default:   ram_addr = '0;
        endcase
    end

    khr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_ring (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign st.span_gt1 = (hi_reg - lo_reg) > NW'(1);
    assign st.wrap     = first_ge_reg || (rd_hash < key_reg);
    assign st.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.take_end)
        begin
            acc_next = HASH_BASIS;
        end
        else if (cmd.acc_step)
        begin
            acc_next = (acc_reg ^ {24'd0, key_byte}) * HASH_MULT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 13'd1;
            acc_reg       <= HASH_BASIS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_end)
        begin
            key_reg <= acc_reg;
        end
        if (cmd.cap_first)
        begin
            first_ge_reg <= rd_hash >= key_reg;
        end
        if (cmd.chk)
        begin
            lo_reg   <= '0;
            hi_reg   <= count_eff;
            pick_reg <= '0;
        end
        if (cmd.mid_lat)
        begin
            mid_reg <= mid_comb;
        end
        if (cmd.cmp)
        begin
            if (rd_hash < key_reg)
            begin
                lo_reg <= mid_reg;
            end
            else
            begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.pick_hi)
        begin
            pick_reg <= hi_reg;
        end
        if (cmd.load_out)
        begin
            out_shard_reg <= rd_node;
            out_hash_reg  <= key_reg;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign shard_index = out_shard_reg;
    assign key_hash    = out_hash_reg;

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |-> (lo_reg < mid_reg) && (mid_reg < hi_reg))
        else $error("probe point outside the search window");

    a_acc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_end |=> acc_reg == HASH_BASIS)
        else $error("hash accumulator not restarted after end of key");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> st.out_free)
        else $error("result register overwritten while still held");

    a_out_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid)
        else $error("captured result not presented");

endmodule

FILE: tb/key_hash_ring_dispatch_top_tb.sv
`timescale 1ns / 1ps

module key_hash_ring_dispatch_top_tb;
    import khr_pkg::*;

    localparam int RING_SLOTS   = 4096;
    localparam int QUIET_LIMIT  = 5000;  // cycles with no word moving on any port
    localparam int HOLD_CYCLES  = 600;   // long output hold-off
    localparam int SETTLE_WAIT  = 64;    // above the worst search latency
    localparam int PHASE_WORDS  = 40;    // random words per point-count setting
    localparam int DRAIN_PHASE  = 5;

    // Unused request code: the block must drop it without any effect.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Request word, last field in the lowest bits.
    typedef struct packed {
        logic [7:0]  key_byte;
        logic [3:0]  point_node;
        logic [31:0] point_hash;
        logic [11:0] point_index;
    } ring_word_t;

    // Result word, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [31:0] key_hash;
        logic [3:0]  shard_index;
    } shard_result_t;

    // Keeps its own copy of the ring, the hash accumulator and point_count,
    // and the queue of shard look-ups still owed by the block.
    class shard_scoreboard;
        logic [31:0]   ring_hash [RING_SLOTS];
        logic [3:0]    ring_node [RING_SLOTS];
        logic [31:0]   fnv_acc;
        logic [12:0]   point_count;
        shard_result_t awaited[$];
        int            errors;
        int            loads;
        int            key_bytes;
        int            lookups;
        int            wraps;
        int            spares;

        function new();
            fnv_acc     = HASH_BASIS;
            point_count = 13'd1;
            errors      = 0;
            loads       = 0;
            key_bytes   = 0;
            lookups     = 0;
            wraps       = 0;
            spares      = 0;
        endfunction

        function int useful_words();
            return loads + key_bytes + lookups;
        endfunction

        function void note_input(input logic [1:0] kind, input ring_word_t w);
            int            span;
            int            lo;
            int            hi;
            int            mid;
            int            pick;
            shard_result_t r;
            case (kind)
                REQ_LOAD:
                begin
                    ring_hash[w.point_index] = w.point_hash;
                    ring_node[w.point_index] = w.point_node;
                    loads++;
                end
                REQ_BYTE:
                begin
                    fnv_acc = (fnv_acc ^ {24'd0, w.key_byte}) * HASH_MULT;
                    key_bytes++;
                end
                REQ_END:
                begin
                    // zero acts as one point, anything above the table saturates
                    span = (point_count == 13'd0) ? 1 :
                           ((point_count > RING_SLOTS) ? RING_SLOTS : int'(point_count));
                    pick = 0;
                    if (ring_hash[0] < fnv_acc && ring_hash[span - 1] >= fnv_acc)
                    begin
                        lo = 0;
                        hi = span;
                        while (hi - lo > 1)
                        begin
                            mid = (lo + hi) / 2;
                            if (ring_hash[mid] < fnv_acc)
                                lo = mid;
                            else
                                hi = mid;
                        end
                        pick = hi;
                    end
                    else
                        wraps++;
                    r             = '0;
                    r.shard_index = ring_node[pick];
                    r.key_hash    = fnv_acc;
                    awaited.push_back(r);
                    fnv_acc = HASH_BASIS;
                    lookups++;
                end
                default:
                    spares++;
            endcase
        endfunction

        function void check_result(input shard_result_t got);
            shard_result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: shard_index %0d, key_hash %08h",
                       got.shard_index, got.key_hash);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.shard_index !== want.shard_index)
            begin
                $error("shard_index: expected %0d, got %0d",
                       want.shard_index, got.shard_index);
                errors++;
            end
            if (got.key_hash !== want.key_hash)
            begin
                $error("key_hash: expected %08h, got %08h", want.key_hash, got.key_hash);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;      // point_index, point_hash, point_node, key_byte
    logic [1:0]  s_tuser;      // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;      // shard_index, key_hash, zero pad

    shard_scoreboard board = new();

    logic steady_sender = 1'b0;  // no gaps between request words while set
    logic hold_req      = 1'b0;  // ask the receiver for the long hold-off
    logic hold_active   = 1'b0;  // receiver is in the hold-off now
    int   quiet_cycles  = 0;

    key_hash_ring_dispatch_top #(
        .MAX_POINTS (RING_SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check every result word taken at this edge against the oldest look-up owed.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(shard_result_t'(m_tdata));
    end

    // Stop a hung run: count edges at which no word moves and no register is written.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: nothing moved for %0d cycles, %0d look-ups outstanding",
                     QUIET_LIMIT, board.awaited.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: ready runs of random length, mostly short stalls, now and then
    // a long one, and on request one long hold-off so the output register and
    // then the request input back up.
    initial
    begin
        int run_len;
        int stall_len;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_active = 1'b1;
                m_tready   <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end
            run_len = ($urandom_range(9) == 0) ? $urandom_range(300, 100) :
                                                 $urandom_range(20, 1);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            case ($urandom_range(9))
                0, 1, 2, 3: stall_len = 0;
                9:          stall_len = $urandom_range(40, 10);
                default:    stall_len = $urandom_range(3, 1);
            endcase
            if (stall_len != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    function automatic ring_word_t mk_word(input logic [11:0] idx, input logic [31:0] h,
                                           input logic [3:0] node, input logic [7:0] kb);
        ring_word_t w;
        w.point_index = idx;
        w.point_hash  = h;
        w.point_node  = node;
        w.key_byte    = kb;
        return w;
    endfunction

    function automatic ring_word_t rand_word();
        return mk_word(12'($urandom_range(4095)), 32'($urandom),
                       4'($urandom_range(15)), 8'($urandom_range(255)));
    endfunction

    // Mostly back to back or short gaps, a few long ones.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (steady_sender || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Offer one request word, hold it until taken, then note it. Valid stays
    // high across a zero gap so back-to-back words need no second assignment.
    task automatic send_word(input logic [1:0] kind, input ring_word_t w);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(kind, w);
        gap = idle_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Key bytes with random filler in the unused fields, a spare word thrown
    // in now and then, closed by an end-of-key word.
    task automatic send_key(input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
                send_word(REQ_SPARE, rand_word());
            send_word(REQ_BYTE, rand_word());
        end
        send_word(REQ_END, rand_word());
    endtask

    function automatic int key_len();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        else if (r < 80)
            return $urandom_range(8, 1);
        else
            return $urandom_range(40, 9);
    endfunction

    // Below the full depth: load slots 0..span-1 with a table sorted ascending
    // and spread over the whole hash range, one point per equal slice. Where the
    // basis falls in a slice the point sits exactly on it, so an empty key hits
    // a point dead on.
    // Full depth: load slot 0 and every slot that a search moving always right
    // visits, all at hash zero, and the last slot at a random upper hash. Each
    // key then either wraps or walks the whole right-hand path, so the search
    // runs all its steps and never reads an unloaded slot.
    task automatic load_ring(input int span);
        longint unsigned step;
        longint unsigned lo;
        logic [31:0]     h;
        int              left;
        int              mid;
        if (span >= RING_SLOTS)
        begin
            send_word(REQ_LOAD, mk_word(12'd0, 32'd0, 4'($urandom_range(15)),
                                        8'($urandom_range(255))));
            left = 0;
            while (RING_SLOTS - left > 2)
            begin
                mid = (left + RING_SLOTS) / 2;
                send_word(REQ_LOAD, mk_word(12'(mid), 32'd0, 4'($urandom_range(15)),
                                            8'($urandom_range(255))));
                left = mid;
            end
            send_word(REQ_LOAD, mk_word(12'(RING_SLOTS - 1), {1'b1, 31'($urandom)},
                                        4'($urandom_range(15)), 8'($urandom_range(255))));
        end
        else
        begin
            step = 64'h1_0000_0000 / span;
            for (int i = 0; i < span; i++)
            begin
                lo = step * i;
                if (HASH_BASIS >= lo && HASH_BASIS < lo + step)
                    h = HASH_BASIS;
                else
                    h = 32'(lo + $urandom_range(32'(step - 1), 0));
                send_word(REQ_LOAD, mk_word(12'(i), h, 4'($urandom_range(15)),
                                            8'($urandom_range(255))));
            end
        end
    endtask

    // Mostly well-formed keys, the rest stray loads (which may unsort the
    // table) and spare words. Spare words do not count toward the budget.
    task automatic random_burst(input int words);
        int         start;
        int         r;
        ring_word_t w;
        start = board.useful_words();
        while (board.useful_words() - start < words)
        begin
            r = $urandom_range(99);
            if (r < 85)
                send_key(key_len());
            else if (r < 95)
            begin
                w = rand_word();
                // The full-depth table holds only slot 0 and the right-hand
                // path; aim stray loads at the left half, which no search reads.
                if (board.point_count >= RING_SLOTS)
                    w.point_index = 12'($urandom_range(RING_SLOTS / 2 - 1, 1));
                send_word(REQ_LOAD, w);
            end
            else
                send_word(REQ_SPARE, rand_word());
        end
    endtask

    // Drop valid, wait for every owed result, then let any search still running
    // finish before touching the register.
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_point_count(input logic [12:0] count);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.point_count = count;
    endtask

    initial
    begin
        logic [12:0] counts [10];
        int          span;
        counts = '{13'd4096, 13'd8191, 13'd4097, 13'd0, 13'd1,
                   13'd2, 13'd3, 13'd5, 13'd16, 13'd40};

        rst_n      = 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_LOAD;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset point count of one: only slot 0 is searched.
        // First point sits on the basis, so the empty key compares equal to it.
        send_word(REQ_LOAD, mk_word(12'd0, HASH_BASIS, 4'hF, 8'h00));
        send_word(REQ_END, mk_word(12'd0, 32'd0, 4'd0, 8'h00));
        // Top slot with the all-ones hash, outside the searched range.
        send_word(REQ_LOAD, mk_word(12'hFFF, 32'hFFFF_FFFF, 4'h0, 8'hFF));
        // Byte extremes with every unused field at all ones, then all zeros.
        send_word(REQ_BYTE, mk_word(12'hFFF, 32'hFFFF_FFFF, 4'hF, 8'h00));
        send_word(REQ_SPARE, mk_word(12'hFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF));
        send_word(REQ_BYTE, mk_word(12'h000, 32'h0000_0000, 4'h0, 8'hFF));
        send_word(REQ_SPARE, mk_word(12'h000, 32'h0000_0000, 4'h0, 8'h00));
        send_word(REQ_BYTE, mk_word(12'h5A5, 32'hA5A5_5A5A, 4'h5, 8'h80));
        send_word(REQ_END, mk_word(12'hFFF, 32'hFFFF_FFFF, 4'hF, 8'hFF));
        // First point at hash zero: every key lands above the last point and wraps.
        send_word(REQ_LOAD, mk_word(12'd0, 32'd0, 4'h0, 8'hFF));
        send_word(REQ_BYTE, mk_word(12'd0, 32'd0, 4'd0, 8'h01));
        send_word(REQ_END, mk_word(12'd0, 32'd0, 4'd0, 8'h00));
        send_word(REQ_END, mk_word(12'd0, 32'd0, 4'd0, 8'h00));
        send_word(REQ_SPARE, mk_word(12'd0, 32'd0, 4'd0, 8'h00));
        send_word(REQ_END, mk_word(12'd0, 32'd0, 4'd0, 8'h00));

        // One phase per point-count setting: reload a sorted table wherever the
        // count reaches it, then random traffic. The saturating counts reuse
        // the full-depth table loaded for 4096.
        foreach (counts[p])
        begin
            settle(SETTLE_WAIT);
            write_point_count(counts[p]);
            steady_sender = ($urandom_range(3) == 0);
            span = (counts[p] == 13'd0) ? 1 : int'(counts[p]);
            if (span <= RING_SLOTS)
                load_ring(span);

            if (p == 0)
            begin
                // Hold the receiver off and keep offering keys back to back,
                // so a result waits in the output register and the next end
                // of key stalls the input.
                s_tvalid <= 1'b0;
                hold_req  = 1'b1;
                while (!hold_active)
                    @(posedge clk);
                steady_sender = 1'b1;
                repeat (12) send_key($urandom_range(6));
                steady_sender = 1'b0;
            end

            random_burst(PHASE_WORDS / 2);
            if (p == DRAIN_PHASE)
                settle(1);
            random_burst(PHASE_WORDS / 2);
        end

        settle(SETTLE_WAIT);

        $display("Covered %0d loads, %0d key bytes, %0d look-ups (%0d wrapped to slot 0),",
                 board.loads, board.key_bytes, board.lookups, board.wraps);
        $display("%0d spare words, %0d point-count settings incl. zero and saturation",
                 board.spares, $size(counts));
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/khr_pkg.sv
rtl/khr_ram.sv
rtl/khr_ctrl.sv
rtl/khr_dp.sv
rtl/key_hash_ring_dispatch_top.sv
tb/key_hash_ring_dispatch_top_tb.sv
